// File: hw/rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// shared constants for the circle pair contact pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

	// default geometry of the datapath
	localparam int unsigned CPC_COORD_WIDTH      = 32;
	localparam int unsigned CPC_NORMAL_FRAC_BITS = 14;
	localparam int unsigned CPC_TAG_WIDTH        = 16;

endpackage

`default_nettype wire

// File: hw/rtl/circle_pair_contact_core.sv
// throughput: one request per cycle, busy is never raised; the pipeline has no stall path
// the depth is set by the square root (one root bit per stage) and the two normal
// dividers (one quotient bit per stage each), run side by side
// reset: arst_n clears every stage valid bit at once; payload registers are not reset
// ----------------------------------------------------------------------------
// circle_pair_contact_core
// narrow-phase circle against circle contact test: hit flag, depth and unit normal
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pair_contact_core #(
	parameter int unsigned COORD_WIDTH      = cpc_pkg::CPC_COORD_WIDTH,
	parameter int unsigned NORMAL_FRAC_BITS = cpc_pkg::CPC_NORMAL_FRAC_BITS,
	parameter int unsigned TAG_WIDTH        = cpc_pkg::CPC_TAG_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [TAG_WIDTH-1:0]               pair_tag,
	input  wire logic signed [COORD_WIDTH-1:0]      first_center_x,
	input  wire logic signed [COORD_WIDTH-1:0]      first_center_y,
	input  wire logic [COORD_WIDTH-2:0]             first_radius,
	input  wire logic signed [COORD_WIDTH-1:0]      second_center_x,
	input  wire logic signed [COORD_WIDTH-1:0]      second_center_y,
	input  wire logic [COORD_WIDTH-2:0]             second_radius,
	output logic                                    done,
	output logic [TAG_WIDTH-1:0]                    tag_out,
	output logic                                    hit,
	output logic [COORD_WIDTH-1:0]                  contact_depth,
	output logic signed [NORMAL_FRAC_BITS+1:0]      normal_x,
	output logic signed [NORMAL_FRAC_BITS+1:0]      normal_y
);
	import cpc_pkg::*;

	// offset and distance width: one more than a coordinate
	localparam int unsigned W   = COORD_WIDTH + 1;
	// squared length width
	localparam int unsigned D2W = 2 * W;
	// square root remainder width
	localparam int unsigned RW  = W + 2;
	localparam int unsigned NF  = NORMAL_FRAC_BITS;
	localparam int unsigned NW  = NF + 2;
	localparam int unsigned LAT = 7 + W + NF;

	// data that rides along the root and divider stages
	typedef struct packed {
		logic [TAG_WIDTH-1:0]   tag;
		logic [COORD_WIDTH-1:0] rsum;
		logic [COORD_WIDTH-2:0] r1;
		logic [W-1:0]           ax;
		logic [W-1:0]           ay;
		logic                   nx;
		logic                   ny;
		logic                   hit;
		logic                   zero;
	} side_t;

	// requests are never held off
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1: center offsets and radius sum ----------------
	logic                   vld_s1;
	logic [TAG_WIDTH-1:0]   tag_s1;
	logic signed [W-1:0]    dx_s1, dy_s1;
	logic [COORD_WIDTH-1:0] rsum_s1;
	logic [COORD_WIDTH-2:0] r1_s1;

	always_ff @(posedge clk) begin
		tag_s1  <= pair_tag;
		dx_s1   <= W'(second_center_x) - W'(first_center_x);
		dy_s1   <= W'(second_center_y) - W'(first_center_y);
		rsum_s1 <= {1'b0, first_radius} + {1'b0, second_radius};
		r1_s1   <= first_radius;
	end

	// ---------------- stage 2: magnitudes and signs ----------------
	logic                   vld_s2;
	logic [TAG_WIDTH-1:0]   tag_s2;
	logic [W-1:0]           ax_s2, ay_s2;
	logic                   nx_s2, ny_s2;
	logic [COORD_WIDTH-1:0] rsum_s2;
	logic [COORD_WIDTH-2:0] r1_s2;

	always_ff @(posedge clk) begin
		tag_s2  <= tag_s1;
		nx_s2   <= dx_s1[W-1];
		ny_s2   <= dy_s1[W-1];
		ax_s2   <= dx_s1[W-1] ? (W'(0) - dx_s1) : dx_s1;
		ay_s2   <= dy_s1[W-1] ? (W'(0) - dy_s1) : dy_s1;
		rsum_s2 <= rsum_s1;
		r1_s2   <= r1_s1;
	end

	// ---------------- stage 3: squares ----------------
	logic                     vld_s3;
	logic [TAG_WIDTH-1:0]     tag_s3;
	logic [D2W-1:0]           ax2_s3, ay2_s3;
	logic [2*COORD_WIDTH-1:0] rs2_s3;
	logic [W-1:0]             ax_s3, ay_s3;
	logic                     nx_s3, ny_s3;
	logic [COORD_WIDTH-1:0]   rsum_s3;
	logic [COORD_WIDTH-2:0]   r1_s3;

	always_ff @(posedge clk) begin
		tag_s3  <= tag_s2;
		ax2_s3  <= ax_s2 * ax_s2;
		ay2_s3  <= ay_s2 * ay_s2;
		rs2_s3  <= rsum_s2 * rsum_s2;
		ax_s3   <= ax_s2;
		ay_s3   <= ay_s2;
		nx_s3   <= nx_s2;
		ny_s3   <= ny_s2;
		rsum_s3 <= rsum_s2;
		r1_s3   <= r1_s2;
	end

	// ---------------- stage 4: squared length ----------------
	logic                     vld_s4;
	logic [TAG_WIDTH-1:0]     tag_s4;
	logic [D2W-1:0]           d2_s4;
	logic [2*COORD_WIDTH-1:0] rs2_s4;
	logic [W-1:0]             ax_s4, ay_s4;
	logic                     nx_s4, ny_s4;
	logic [COORD_WIDTH-1:0]   rsum_s4;
	logic [COORD_WIDTH-2:0]   r1_s4;

	always_ff @(posedge clk) begin
		tag_s4  <= tag_s3;
		d2_s4   <= ax2_s3 + ay2_s3;
		rs2_s4  <= rs2_s3;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
		nx_s4   <= nx_s3;
		ny_s4   <= ny_s3;
		rsum_s4 <= rsum_s3;
		r1_s4   <= r1_s3;
	end

	// ---------------- stage 5: touch test, coincident centers ----------------
	logic           vld_s5;
	logic [D2W-1:0] d2_s5;
	side_t          sd_s5;

	always_ff @(posedge clk) begin
		d2_s5        <= d2_s4;
		sd_s5.tag    <= tag_s4;
		sd_s5.rsum   <= rsum_s4;
		sd_s5.r1     <= r1_s4;
		sd_s5.ax     <= ax_s4;
		sd_s5.ay     <= ay_s4;
		sd_s5.nx     <= nx_s4;
		sd_s5.ny     <= ny_s4;
		// touching counts as a hit
		sd_s5.hit    <= d2_s4 <= D2W'(rs2_s4);
		sd_s5.zero   <= d2_s4 == '0;
	end

	// ---------------- square root: one root bit per stage ----------------
	logic [RW-1:0]  sq_rem  [0:W];
	logic [W-1:0]   sq_root [0:W];
	logic [D2W-1:0] sq_d2   [0:W];
	side_t          sq_sd   [0:W];
	logic           sq_vld  [0:W];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_d2[0]   = d2_s5;
	assign sq_sd[0]   = sd_s5;
	assign sq_vld[0]  = vld_s5;

	for (genvar g = 0; g < W; g++) begin : g_sqrt
		logic [RW-1:0] rem_sh, trial;
		logic          take;

		always_comb begin
			// bring down the next two bits of the radicand
			rem_sh = {sq_rem[g][RW-3:0], sq_d2[g][D2W-1 -: 2]};
			trial  = {sq_root[g], 2'b01};
			take   = rem_sh >= trial;
		end

		always_ff @(posedge clk) begin
			sq_rem[g+1]  <= take ? (rem_sh - trial) : rem_sh;
			sq_root[g+1] <= {sq_root[g][W-2:0], take};
			sq_d2[g+1]   <= {sq_d2[g][D2W-3:0], 2'b00};
			sq_sd[g+1]   <= sq_sd[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[g+1] <= 1'b0;
			end else begin
				sq_vld[g+1] <= sq_vld[g];
			end
		end
	end

	// ---------------- divider setup ----------------
	logic [W:0]    dv_rx [0:NF];
	logic [W:0]    dv_ry [0:NF];
	logic [NF-1:0] dv_qx [0:NF];
	logic [NF-1:0] dv_qy [0:NF];
	logic [W-1:0]  dv_den [0:NF];
	logic          dv_eqx [0:NF];
	logic          dv_eqy [0:NF];
	side_t         dv_sd [0:NF];
	logic          dv_vld [0:NF];

	// floor root is never below either magnitude, so "not below" means equal
	always_ff @(posedge clk) begin
		dv_rx[0]  <= {1'b0, sq_sd[W].ax};
		dv_ry[0]  <= {1'b0, sq_sd[W].ay};
		dv_qx[0]  <= '0;
		dv_qy[0]  <= '0;
		dv_den[0] <= sq_root[W];
		dv_eqx[0] <= sq_sd[W].ax >= sq_root[W];
		dv_eqy[0] <= sq_sd[W].ay >= sq_root[W];
		dv_sd[0]  <= sq_sd[W];
	end

	// ---------------- normal dividers: one quotient bit per stage ----------------
	for (genvar g = 0; g < NF; g++) begin : g_div
		logic [W:0] shx, shy;
		logic       gex, gey;

		always_comb begin
			shx = {dv_rx[g][W-1:0], 1'b0};
			shy = {dv_ry[g][W-1:0], 1'b0};
			gex = shx >= {1'b0, dv_den[g]};
			gey = shy >= {1'b0, dv_den[g]};
		end

		always_ff @(posedge clk) begin
			dv_rx[g+1]  <= gex ? (shx - {1'b0, dv_den[g]}) : shx;
			dv_ry[g+1]  <= gey ? (shy - {1'b0, dv_den[g]}) : shy;
			dv_qx[g+1]  <= {dv_qx[g][NF-2:0], gex};
			dv_qy[g+1]  <= {dv_qy[g][NF-2:0], gey};
			dv_den[g+1] <= dv_den[g];
			dv_eqx[g+1] <= dv_eqx[g];
			dv_eqy[g+1] <= dv_eqy[g];
			dv_sd[g+1]  <= dv_sd[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[g+1] <= 1'b0;
			end else begin
				dv_vld[g+1] <= dv_vld[g];
			end
		end
	end

	// ---------------- output stage ----------------
	localparam logic [NF:0] ONE_MAG = (NF+1)'(1) << NF;

	side_t          fin;
	logic [NF:0]    mag_x, mag_y;
	logic [NW-1:0]  sx, sy;

	always_comb begin
		fin   = dv_sd[NF];
		// coincident centers point along +x
		mag_x = (fin.zero || dv_eqx[NF]) ? ONE_MAG : {1'b0, dv_qx[NF]};
		mag_y = fin.zero ? '0 : (dv_eqy[NF] ? ONE_MAG : {1'b0, dv_qy[NF]});
		sx    = fin.nx ? (NW'(0) - {1'b0, mag_x}) : {1'b0, mag_x};
		sy    = fin.ny ? (NW'(0) - {1'b0, mag_y}) : {1'b0, mag_y};
	end

	always_ff @(posedge clk) begin
		tag_out <= fin.tag;
		hit     <= fin.hit;
		if (!fin.hit) begin
			contact_depth <= '0;
			normal_x      <= '0;
			normal_y      <= '0;
		end else begin
			contact_depth <= fin.zero ? {1'b0, fin.r1}
			                          : (fin.rsum - dv_den[NF][COORD_WIDTH-1:0]);
			normal_x      <= sx;
			normal_y      <= sy;
		end
	end

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			dv_vld[0] <= 1'b0;
			done      <= 1'b0;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			dv_vld[0] <= sq_vld[W];
			done      <= dv_vld[NF];
		end
	end

	// ---------------- assertions ----------------
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("request did not come out after the pipeline latency");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (contact_depth == '0 && normal_x == '0 && normal_y == '0))
		else $error("miss carries nonzero contact fields");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= $signed(NW'(ONE_MAG)) && normal_x >= -$signed(NW'(ONE_MAG))
		       && normal_y <= $signed(NW'(ONE_MAG)) && normal_y >= -$signed(NW'(ONE_MAG))))
		else $error("normal component outside unit range");

endmodule

`default_nettype wire

// File: tb/sv/tb_circle_pair_contact_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_pair_contact_core
// self-checking bench for the circle pair contact pipeline: a table of corner
// pairs with typed-in or predicted results, then random pairs biased toward
// touching circles, checked by an in-bench contact predictor under several idling phases
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circle_pair_contact_core;
	import cpc_pkg::*;

	localparam int unsigned CW = CPC_COORD_WIDTH;
	localparam int unsigned NF = CPC_NORMAL_FRAC_BITS;
	localparam int unsigned TW = CPC_TAG_WIDTH;
	localparam int LATENCY     = 7 + (CW + 1) + NF;
	localparam int N_RANDOM    = 1700;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		logic [TW-1:0]          tag;
		logic signed [CW-1:0]   ax, ay;
		logic [CW-2:0]          ar;
		logic signed [CW-1:0]   bx, by;
		logic [CW-2:0]          br;
	} pair_t;

	typedef struct {
		logic [TW-1:0]          tag;
		logic                   hit;
		logic [CW-1:0]          depth;
		logic signed [NF+1:0]   nx, ny;
	} contact_t;

	// directed row: pair plus an optional typed-in expectation
	typedef struct {
		pair_t    p;
		logic     fixed;
		contact_t c;
	} row_t;

	logic                  clk, arst_n, start;
	logic [TW-1:0]         pair_tag;
	logic signed [CW-1:0]  first_center_x, first_center_y;
	logic [CW-2:0]         first_radius;
	logic signed [CW-1:0]  second_center_x, second_center_y;
	logic [CW-2:0]         second_radius;
	wire                   busy, done, hit;
	wire [TW-1:0]          tag_out;
	wire [CW-1:0]          contact_depth;
	wire signed [NF+1:0]   normal_x, normal_y;

	circle_pair_contact_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pair_tag(pair_tag),
		.first_center_x(first_center_x), .first_center_y(first_center_y),
		.first_radius(first_radius),
		.second_center_x(second_center_x), .second_center_y(second_center_y),
		.second_radius(second_radius),
		.done(done), .tag_out(tag_out), .hit(hit), .contact_depth(contact_depth),
		.normal_x(normal_x), .normal_y(normal_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	contact_t pending_contacts[$];
	int       mismatches = 0;
	int       results_seen = 0;
	int       hits_seen = 0;
	int       requests_sent = 0;
	longint   cycles = 0;

	// floor(num * 2^NF / den), saturating at 1.0 when num reaches den
	function automatic logic [NF:0] unit_fraction(logic [63:0] num, logic [63:0] den);
		logic [NF:0]  q;
		logic [64:0]  r;
		q = '0;
		r = {1'b0, num};
		if (num >= den)
			return (NF+1)'(1) << NF;
		for (int i = 0; i < NF; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic contact_t predict_contact(pair_t p);
		contact_t     c;
		logic signed [CW:0] dx, dy;
		logic [CW:0]  mx, my;
		logic [CW:0]  rsum;
		logic [127:0] d2, root, cand;
		logic [NF:0]  ux, uy;
		dx   = (CW+1)'(p.bx) - (CW+1)'(p.ax);
		dy   = (CW+1)'(p.by) - (CW+1)'(p.ay);
		mx   = dx[CW] ? -dx : dx;
		my   = dy[CW] ? -dy : dy;
		rsum = {2'b00, p.ar} + {2'b00, p.br};
		d2   = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
		c.tag = p.tag;
		c.hit = 1'b0; c.depth = '0; c.nx = '0; c.ny = '0;
		if (d2 > 128'(rsum) * 128'(rsum))
			return c;
		c.hit = 1'b1;
		// coincident centres: depth is the first radius, normal points along +x
		if (d2 == 0) begin
			c.depth = {1'b0, p.ar};
			c.nx = (NF+2)'(1) << NF;
			return c;
		end
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = root | (128'd1 << i);
			if (cand * cand <= d2)
				root = cand;
		end
		c.depth = CW'(rsum - root);
		ux = unit_fraction(64'(mx), root[63:0]);
		uy = unit_fraction(64'(my), root[63:0]);
		c.nx = dx[CW] ? -$signed({1'b0, ux}) : $signed({1'b0, ux});
		c.ny = dy[CW] ? -$signed({1'b0, uy}) : $signed({1'b0, uy});
		return c;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
	endtask

	// results: one strobe cycle each, compared with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			contact_t w;
			if (pending_contacts.size() == 0) begin
				report_mismatch("unexpected result, tag", tag_out, -1);
			end else begin
				w = pending_contacts.pop_front();
				if (tag_out !== w.tag) report_mismatch("tag_out", tag_out, w.tag);
				if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
				if (contact_depth !== w.depth)
					report_mismatch("contact_depth", contact_depth, w.depth);
				if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
				if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
				if (w.hit) hits_seen++;
			end
			results_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	int idle_pct = 0;

	// one request; optional idle gap drawn from the current phase
	task automatic send_pair(pair_t p, contact_t want);
		while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start           <= 1'b1;
		pair_tag        <= p.tag;
		first_center_x  <= p.ax;
		first_center_y  <= p.ay;
		first_radius    <= p.ar;
		second_center_x <= p.bx;
		second_center_y <= p.by;
		second_radius   <= p.br;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_contacts = {pending_contacts, want};
		requests_sent++;
	endtask

	function automatic logic [CW-2:0] any_radius();
		case ($urandom_range(3, 0))
			0: return (CW-1)'($urandom_range(1 << 30, 0));
			1: return (CW-1)'($urandom_range(32'h000F_FFFF, 0));
			2: return (CW-1)'(1 << 30);
			default: return (CW-1)'($urandom() >> 1);   // above the nominal range too
		endcase
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		logic signed [CW-1:0] span;
		p.tag = TW'($urandom());
		p.ar  = any_radius();
		p.br  = any_radius();
		p.ax  = $urandom();
		p.ay  = $urandom();
		case ($urandom_range(9, 0))
			// nearby circles, mostly touching or overlapping
			0, 1, 2, 3, 4: begin
				span = $urandom_range(32'h0002_0000, 1);
				p.ar = (CW-1)'($urandom_range(32'h0001_0000, 0));
				p.br = (CW-1)'($urandom_range(32'h0001_0000, 0));
				p.bx = p.ax + $signed($urandom_range(2 * span, 0)) - span;
				p.by = p.ay + $signed($urandom_range(2 * span, 0)) - span;
			end
			// large circles with small to moderate offsets
			5, 6: begin
				p.bx = p.ax + ($signed($urandom()) >>> $urandom_range(31, 2));
				p.by = p.ay + ($signed($urandom()) >>> $urandom_range(31, 2));
			end
			// offset along x, with y equal or one apart, or coincident
			7: begin
				p.bx = p.ax + ($signed($urandom()) >>> $urandom_range(31, 0));
				p.by = $urandom_range(1, 0) ? p.ay : p.ay + 1;
				if ($urandom_range(3, 0) == 0) begin
					p.bx = p.ax;
					p.by = p.ay;
				end
			end
			default: begin
				p.bx = $urandom();
				p.by = $urandom();
			end
		endcase
		return p;
	endfunction

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-2:0]        RMAX = {(CW-1){1'b1}};
	localparam logic [CW-2:0]        RTOP = (CW-1)'(1) << 30;
	localparam logic [CW-2:0]        ONE  = (CW-1)'(1) << 16;
	localparam logic [NF+1:0]        UNIT = (NF+2)'(1) << NF;

	row_t corner_rows[] = '{
		// coincident at origin, zero radii: touching
		'{'{16'h0000, 0, 0, 0, 0, 0, 0}, 1'b1, '{16'h0000, 1'b1, 0, UNIT, 0}},
		// coincident: depth is first radius
		'{'{16'hFFFF, CMAX, CMIN, RMAX, CMAX, CMIN, 0}, 1'b1,
			'{16'hFFFF, 1'b1, RMAX, UNIT, 0}},
		'{'{16'h1234, 5, 7, ONE, 5, 7, RMAX}, 1'b1, '{16'h1234, 1'b1, ONE, UNIT, 0}},
		// extremes of the plane, zero radii: apart
		'{'{16'h5555, CMIN, CMIN, 0, CMAX, CMAX, 0}, 1'b1, '{16'h5555, 1'b0, 0, 0, 0}},
		'{'{16'hAAAA, CMAX, CMAX, 0, CMIN, CMIN, 0}, 1'b1, '{16'hAAAA, 1'b0, 0, 0, 0}},
		// exactly touching along each axis, both directions
		'{'{16'h0001, 0, 0, ONE, 2 * ONE, 0, ONE}, 1'b1, '{16'h0001, 1'b1, 0, UNIT, 0}},
		'{'{16'h0002, 0, 0, ONE, -2 * ONE, 0, ONE}, 1'b1,
			'{16'h0002, 1'b1, 0, -UNIT, 0}},
		'{'{16'h0003, 0, 0, ONE, 0, 2 * ONE, ONE}, 1'b1, '{16'h0003, 1'b1, 0, 0, UNIT}},
		'{'{16'h0004, 0, 0, ONE, 0, -2 * ONE, ONE}, 1'b1,
			'{16'h0004, 1'b1, 0, 0, -UNIT}},
		// one unit short of touching
		'{'{16'h0005, 0, 0, ONE, 2 * ONE + 1, 0, ONE}, 1'b1, '{16'h0005, 1'b0, 0, 0, 0}},
		// biggest radii across the whole plane
		'{'{16'h0006, CMIN, CMIN, RMAX, CMAX, CMAX, RMAX}, 1'b0, '{default: '0}},
		'{'{16'h0007, CMIN, 0, RTOP, CMAX, 0, RTOP}, 1'b0, '{default: '0}},
		'{'{16'h0008, CMAX, CMIN, RTOP, CMIN, CMAX, RTOP}, 1'b0, '{default: '0}},
		// diagonal and off-axis overlaps in all quadrants
		'{'{16'h0009, 0, 0, 3 * ONE, 3 * ONE, 4 * ONE, 3 * ONE}, 1'b0, '{default: '0}},
		'{'{16'h000A, 0, 0, 3 * ONE, -3 * ONE, 4 * ONE, 3 * ONE}, 1'b0, '{default: '0}},
		'{'{16'h000B, 0, 0, 3 * ONE, 3 * ONE, -4 * ONE, 3 * ONE}, 1'b0, '{default: '0}},
		'{'{16'h000C, 7, -9, 3 * ONE, -3 * ONE, -4 * ONE, 3 * ONE}, 1'b0, '{default: '0}},
		'{'{16'h000D, 0, 0, 1, 1, 1, 1}, 1'b0, '{default: '0}},
		'{'{16'h000E, CMAX, CMAX, RMAX, CMAX - 1, CMAX, 0}, 1'b0, '{default: '0}},
		'{'{16'h000F, CMIN, CMIN, 0, CMIN + 1, CMIN + 1, RMAX}, 1'b0, '{default: '0}}
	};

	initial begin
		contact_t want;
		pair_t    p;
		int       phase_pct[4];
		phase_pct = '{0, 82, 0, 17};
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		pair_tag = '0;
		first_center_x = '0; first_center_y = '0; first_radius = '0;
		second_center_x = '0; second_center_y = '0; second_radius = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed-in results where fixed, predictor otherwise
		foreach (corner_rows[i]) begin
			want = corner_rows[i].fixed ? corner_rows[i].c : predict_contact(corner_rows[i].p);
			send_pair(corner_rows[i].p, want);
		end

		// random pairs, four idling phases
		for (int n = 0; n < N_RANDOM; n++) begin
			idle_pct = phase_pct[(n * 4) / N_RANDOM];
			p = random_pair();
			send_pair(p, predict_contact(p));
		end
		start <= 1'b0;

		while (pending_contacts.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d pairs, checked %0d results, %0d of them contacts",
			requests_sent, results_seen, hits_seen);
		if (mismatches == 0 && pending_contacts.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
